// ===== rtl/fpws_pkg.sv =====
// Package for the flash page write stager: request types, result codes,
// configuration register indexes and reset values. No dependencies.
package fpws_pkg;

    typedef struct packed {
        logic [31:0] start_address;
        logic [7:0]  call_length;
        logic [7:0]  byte_index;
        logic [7:0]  byte_value;
    } in_item_t;

    typedef struct packed {
        logic        command;
        logic [31:0] nvm_address;
        logic [31:0] word_value;
        logic        last_of_run;
    } out_item_t;

    // Per-request decision handed from the call control to the sequencer.
    typedef struct packed {
        logic erase;
        logic store;
        logic flush;
    } call_dec_t;

    localparam logic CMD_ERASE_ROW  = 1'b0;
    localparam logic CMD_WRITE_WORD = 1'b1;

    localparam logic [1:0] CFG_SAFE_MODE   = 2'd0;
    localparam logic [1:0] CFG_APP_START   = 2'd1;
    localparam logic [1:0] CFG_FLASH_LIMIT = 2'd2;

    localparam logic        SAFE_MODE_RST   = 1'b1;
    localparam logic [31:0] APP_START_RST   = 32'h0000_2000;
    localparam logic [31:0] FLASH_LIMIT_RST = 32'h0004_0000;

endpackage

// ===== rtl/flash_page_write_stager_core.sv =====
// Flash page write stager top level: configuration registers, flush
// sequencer and output register. Depends on fpws_pkg, fpws_call_ctrl and
// fpws_page_ram.
//
// Each request carries one byte of a flash write call and is taken when no
// page flush is running and the output register is free; a row-aligned
// accepted call first produces an erase-row result. A call ending on a page
// boundary flushes the page as PAGE_BYTES/4 word writes; each word is a read
// of the page memory, then a load of the output register, and the input
// stays stalled until the last word of the page is loaded.
// PAGE_BYTES and ROW_BYTES must be powers of two. The page buffer reads as
// zero from reset; there is no clearing pass.
module flash_page_write_stager_core
    import fpws_pkg::*;
#(
    parameter int PAGE_BYTES = 64,
    parameter int ROW_BYTES  = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    localparam int PB_W  = $clog2(PAGE_BYTES);
    localparam int WORDS = PAGE_BYTES / 4;
    localparam int W_W   = $clog2(WORDS);

    typedef enum logic [1:0] {S_IDLE, S_RD, S_WR} state_t;

    state_t      state_reg;
    logic        safe_mode_reg;
    logic [31:0] app_start_reg, flash_limit_reg;
    logic [W_W-1:0] k_reg;
    logic [31:0] base_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;

    logic        accept, out_free;
    call_dec_t   dec;
    logic [PB_W-1:0] store_addr;
    logic [31:0] page_base, rd_data;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_mode_reg   <= SAFE_MODE_RST;
            app_start_reg   <= APP_START_RST;
            flash_limit_reg <= FLASH_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SAFE_MODE:   safe_mode_reg   <= cfg_data[0];
                CFG_APP_START:   app_start_reg   <= cfg_data;
                CFG_FLASH_LIMIT: flash_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    fpws_call_ctrl #(
        .PAGE_BYTES (PAGE_BYTES),
        .ROW_BYTES  (ROW_BYTES)
    ) u_call_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .safe_mode   (safe_mode_reg),
        .app_floor   (app_start_reg),
        .flash_limit (flash_limit_reg),
        .item        (in_item),
        .accept      (accept),
        .dec         (dec),
        .store_addr  (store_addr),
        .page_base   (page_base)
    );

    fpws_page_ram #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_page_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && dec.store),
        .wr_addr (store_addr),
        .wr_data (in_item.byte_value),
        .rd_en   (state_reg == S_RD),
        .rd_addr (k_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && dec.erase)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_item_reg.command     <= CMD_ERASE_ROW;
                        out_item_reg.nvm_address <= in_item.start_address;
                        out_item_reg.word_value  <= '0;
                        out_item_reg.last_of_run <= !dec.flush;
                    end
                    else if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (accept && dec.flush)
                    begin
                        base_reg  <= page_base;
                        k_reg     <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    // The read data holds here until the output register is free.
                    if (out_free)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_item_reg.command     <= CMD_WRITE_WORD;
                        out_item_reg.nvm_address <= {base_reg[31:PB_W], k_reg, 2'b00};
                        out_item_reg.word_value  <= rd_data;
                        out_item_reg.last_of_run <= (k_reg == W_W'(WORDS - 1));
                        if (k_reg == W_W'(WORDS - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                default:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_flush_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && dec.flush |=> state_reg == S_RD)
        else $error("page flush did not start after its last byte");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("request taken during a page flush");

    a_erase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.command == CMD_ERASE_ROW
            |-> out_item_reg.word_value == 32'd0)
        else $error("erase result carries a non-zero word");

    a_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.command == CMD_WRITE_WORD
            |-> out_item_reg.nvm_address[1:0] == 2'b00)
        else $error("word write address not word aligned");

endmodule

// ===== rtl/fpws_page_ram.sv =====
// Page buffer memory: word-wide synchronous RAM with byte writes and a
// registered read. Per-byte valid flops make unwritten bytes read as zero.
// Depends on nothing.
module fpws_page_ram #(
    parameter int PAGE_BYTES = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [$clog2(PAGE_BYTES)-1:0]      wr_addr,
    input  logic [7:0]                         wr_data,
    input  logic                               rd_en,
    input  logic [$clog2(PAGE_BYTES/4)-1:0]    rd_addr,
    output logic [31:0]                        rd_data
);

    localparam int WORDS = PAGE_BYTES / 4;
    localparam int PB_W  = $clog2(PAGE_BYTES);

    logic [31:0]           mem [WORDS];
    logic [PAGE_BYTES-1:0] bval_reg;
    logic [31:0]           rd_word_reg;
    logic [3:0]            rd_mask_reg;
    logic [31:0]           mask_bits;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[PB_W-1:2]][8*wr_addr[1:0] +: 8] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bval_reg    <= '0;
            rd_mask_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                bval_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_mask_reg <= bval_reg[4*rd_addr +: 4];
            end
        end
    end

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            mask_bits[8*b +: 8] = {8{rd_mask_reg[b]}};
        end
    end

    assign rd_data = rd_word_reg & mask_bits;

endmodule

// ===== rtl/fpws_call_ctrl.sv =====
// Call control: decides on the first byte of a call whether it is taken,
// tracks the current page base and flags erase, byte store and page flush.
// Depends on fpws_pkg.
module fpws_call_ctrl
    import fpws_pkg::*;
#(
    parameter int PAGE_BYTES = 64,
    parameter int ROW_BYTES  = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          safe_mode,
    input  logic [31:0]                   app_floor,
    input  logic [31:0]                   flash_limit,
    input  in_item_t                      item,
    input  logic                          accept,
    output call_dec_t                     dec,
    output logic [$clog2(PAGE_BYTES)-1:0] store_addr,
    output logic [31:0]                   page_base
);

    localparam int PB_W = $clog2(PAGE_BYTES);
    localparam int RB_W = $clog2(ROW_BYTES);

    logic [31:0] cpb_reg, cpb_next;
    logic        call_acc_reg, call_acc_next;
    logic [31:0] end_addr;
    logic        first, safe_ok, ok, acc_eff, last_byte, in_range;
    logic [PB_W-1:0] idx_sum;

    assign end_addr  = item.start_address + 32'(item.call_length);
    assign page_base = {item.start_address[31:PB_W], PB_W'(0)};
    assign first     = (item.call_length == 8'd0) || (item.byte_index == 8'd0);

    always_comb
    begin
        safe_ok = !(safe_mode && ((item.start_address < app_floor) ||
                                  (end_addr >= flash_limit)));
        // A page-aligned start moves the current page before the page check.
        cpb_next = (safe_ok && item.start_address[PB_W-1:0] == '0)
                   ? item.start_address : cpb_reg;
        ok       = safe_ok && (page_base == cpb_next);
        acc_eff  = first ? ok : call_acc_reg;
        call_acc_next = acc_eff;
        in_range  = item.byte_index < item.call_length;
        last_byte = (item.call_length == 8'd0) ||
                    (item.byte_index == item.call_length - 8'd1);
        dec.erase = first && ok && (item.start_address[RB_W-1:0] == '0);
        dec.store = acc_eff && (item.call_length != 8'd0) && in_range;
        dec.flush = acc_eff && last_byte && (end_addr[PB_W-1:0] == '0);
    end

    assign idx_sum    = item.start_address[PB_W-1:0] + PB_W'(item.byte_index);
    assign store_addr = idx_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpb_reg      <= '0;
            call_acc_reg <= 1'b0;
        end
        else if (accept && first)
        begin
            cpb_reg      <= cpb_next;
            call_acc_reg <= call_acc_next;
        end
    end

endmodule
